[hw/rtl/synced_clock_timed_playback_unit_defines.svh]
// assertion helpers for the rtl
`ifndef SYNCED_CLOCK_TIMED_PLAYBACK_UNIT_DEFINES_SVH
`define SYNCED_CLOCK_TIMED_PLAYBACK_UNIT_DEFINES_SVH

// same-cycle implication
`define SCTP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCTP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/sctp_pkg.sv]
package sctp_pkg;

   localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MSB  = 64'h8000_0000_0000_0000;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 288;
   localparam int RSP_DATA_W  = 104;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESYNC  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK   = 2'd3;

   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_SYNC  = 3'd1;
   localparam logic [2:0] CMD_START = 3'd2;
   localparam logic [2:0] CMD_STOP  = 3'd3;
   localparam logic [2:0] CMD_ENTRY = 3'd4;

   localparam logic [7:0]  RST_SAMPLES = 8'd8;
   localparam logic [31:0] RST_RESYNC  = 32'd5000000;
   localparam logic [23:0] RST_STEP    = 24'd10000;
   localparam logic [31:0] RST_BLINK   = 32'd200000;

   typedef enum logic [17:0] {
      S_CLEAR  = 18'h00001,
      S_IDLE   = 18'h00002,
      S_MPREP  = 18'h00004,
      S_MUL    = 18'h00008,
      S_ADJ    = 18'h00010,
      S_ADJ2   = 18'h00020,
      S_EXEC   = 18'h00040,
      S_RDADDR = 18'h00080,
      S_ENTRY  = 18'h00100,
      S_DUE    = 18'h00200,
      S_SYNC2  = 18'h00400,
      S_SYNC3  = 18'h00800,
      S_SYNC4  = 18'h01000,
      S_DPREP  = 18'h02000,
      S_DPREP2 = 18'h04000,
      S_DIV    = 18'h08000,
      S_DSAT   = 18'h10000,
      S_DONE   = 18'h20000
   } state_type;

   function automatic logic [63:0] mag64(input logic [63:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

   // signed saturation of a magnitude with a sign
   function automatic logic [63:0] sat64(input logic [63:0] m, input logic neg);
      if (!neg) begin
         return m[63] ? SMAX : m;
      end
      return m[63] ? MSB : (~m + 64'd1);
   endfunction

endpackage

[hw/rtl/sctp_ram.sv]
module sctp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[hw/rtl/synced_clock_timed_playback_unit.sv]
// an accepted transaction passes multiply set-up, the bit-serial multiply, the adjust steps and
// execute; an idle tick adds the bit-serial blink division, a playing tick with an entry adds
// the entry read and due update, a sync reply the sync steps, and the one closing a round after
// a previous round also the drift division; one transaction at a time: the next is taken once
// the last result is registered; reset is synchronous, then a clearing pass zeroes the entry
// buffer before the first transaction is taken (register writes are taken throughout)
`include "synced_clock_timed_playback_unit_defines.svh"

module synced_clock_timed_playback_unit
   import sctp_pkg::*;
#(
   parameter int HALF_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // cmd
   input  logic [2:0]             req_tuser,
   // local_time, server_receive_time, server_send_time, switch_time, entry_word, entry_first
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // send_sync_request, entry_valid, red, green, blue, hold_steps, led_on, playing,
   // adjusted_time, zero fill
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH = 2 * HALF_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(HALF_DEPTH);
   localparam int RW    = $clog2(HALF_DEPTH + 1);
   localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);
   localparam logic [AW-1:0] HALF_A   = AW'(HALF_DEPTH);
   localparam logic [RW-1:0] HALF_R   = RW'(HALF_DEPTH);
   localparam logic [PW-1:0] WP_LAST  = PW'(HALF_DEPTH - 1);

   state_type state_ff, state_in;

   logic [7:0]  spsync_ff, spsync_in;
   logic [31:0] resync_iv_ff, resync_iv_in;
   logic [23:0] step_ff, step_in;
   logic [31:0] blink_per_ff, blink_per_in;

   logic [2:0]  cmd_ff, cmd_in;
   logic [62:0] local_ff, local_in;
   logic [63:0] srt_ff, srt_in, sst_ff, sst_in, sw_ff, sw_in;
   logic [31:0] ew_ff, ew_in;
   logic        ef_ff, ef_in;

   logic [63:0] request_time_ff, request_time_in;
   logic [7:0]  samples_ff, samples_in;
   logic [63:0] best_rtt_ff, best_rtt_in, best_off_ff, best_off_in;
   logic [63:0] best_time_ff, best_time_in, base_ff, base_in, drift_ff, drift_in;
   logic [63:0] sync_time_ff, sync_time_in, start_ff, start_in, stop_ff, stop_in;
   logic [63:0] due_ff, due_in;
   logic        want_ff, want_in, playing_ff, playing_in, rfh_ff, rfh_in, led_ff, led_in;
   logic [RW-1:0] rp_ff [2];
   logic [RW-1:0] rp_in [2];
   logic [PW-1:0] wp_ff, wp_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic [127:0] prod_ff, prod_in;
   logic [63:0]  md_ff, md_in;
   logic [5:0]   mcnt_ff, mcnt_in;
   logic         mneg_ff, mneg_in;

   logic [63:0] x0_ff, x0_in, x1_ff, x1_in, x2_ff, x2_in, x3_ff, x3_in;
   logic [63:0] part_ff, part_in, corr_ff, corr_in, adj_ff, adj_in, diff_ff, diff_in;

   logic [63:0]  drem_ff, drem_in, dsor_ff, dsor_in, quo_ff, quo_in;
   logic [127:0] dnd_ff, dnd_in;
   logic [6:0]   dcnt_ff, dcnt_in;
   logic         sticky_ff, sticky_in, dneg_ff, dneg_in, dblink_ff, dblink_in;

   logic [31:0] ent_ff, ent_in;
   logic [32:0] sprod_ff, sprod_in;
   logic        send_ff, send_in, valid_ff, valid_in;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [31:0]   ram_wdata, ram_rdata;

   // combinational helpers
   logic [64:0]  msum;
   logic [63:0]  mval, off_v, qv, m_v, d_v;
   logic [64:0]  drem2;
   logic [65:0]  dsub;
   logic         dtake, pl, rh, wh;
   logic [RW-1:0] pos;
   logic [PW-1:0] wpos;
   logic [8:0]   samples_nx;
   logic [8:0]   hold_p1;
   logic [31:0]  per_v;
   logic [31:0]  ent_m;

   sctp_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign msum  = {1'b0, prod_ff[127:64]} + (prod_ff[0] ? {1'b0, md_ff} : 65'd0);
   assign mval  = (|prod_ff[127:104]) ? {64{1'b1}} : prod_ff[103:40];
   assign drem2 = {drem_ff, dnd_ff[127]};
   assign dsub  = {1'b0, drem2} - {2'b0, dsor_ff};
   assign dtake = ~dsub[65];
   assign off_v = x1_ff[63] ? (~x2_ff + 64'd1) : x2_ff;
   assign qv    = sticky_ff ? {64{1'b1}} : quo_ff;
   assign m_v   = mag64(x0_ff);
   assign d_v   = mag64(x1_ff);
   assign per_v = (blink_per_ff == 32'd0) ? 32'd1 : blink_per_ff;
   assign samples_nx = {1'b0, samples_ff} + 9'd1;
   assign hold_p1    = {1'b0, ram_rdata[7:0]} + 9'd1;
   assign ent_m      = valid_ff ? ent_ff : 32'd0;

   always_comb begin
      state_in        = state_ff;
      spsync_in       = spsync_ff;
      resync_iv_in    = resync_iv_ff;
      step_in         = step_ff;
      blink_per_in    = blink_per_ff;
      cmd_in          = cmd_ff;
      local_in        = local_ff;
      srt_in          = srt_ff;
      sst_in          = sst_ff;
      sw_in           = sw_ff;
      ew_in           = ew_ff;
      ef_in           = ef_ff;
      request_time_in = request_time_ff;
      samples_in      = samples_ff;
      best_rtt_in     = best_rtt_ff;
      best_off_in     = best_off_ff;
      best_time_in    = best_time_ff;
      base_in         = base_ff;
      drift_in        = drift_ff;
      sync_time_in    = sync_time_ff;
      start_in        = start_ff;
      stop_in         = stop_ff;
      due_in          = due_ff;
      want_in         = want_ff;
      playing_in      = playing_ff;
      rfh_in          = rfh_ff;
      led_in          = led_ff;
      rp_in[0]        = rp_ff[0];
      rp_in[1]        = rp_ff[1];
      wp_in           = wp_ff;
      clr_in          = clr_ff;
      prod_in         = prod_ff;
      md_in           = md_ff;
      mcnt_in         = mcnt_ff;
      mneg_in         = mneg_ff;
      x0_in           = x0_ff;
      x1_in           = x1_ff;
      x2_in           = x2_ff;
      x3_in           = x3_ff;
      part_in         = part_ff;
      corr_in         = corr_ff;
      adj_in          = adj_ff;
      diff_in         = diff_ff;
      drem_in         = drem_ff;
      dsor_in         = dsor_ff;
      quo_in          = quo_ff;
      dnd_in          = dnd_ff;
      dcnt_in         = dcnt_ff;
      sticky_in       = sticky_ff;
      dneg_in         = dneg_ff;
      dblink_in       = dblink_ff;
      ent_in          = ent_ff;
      sprod_in        = sprod_ff;
      send_in         = send_ff;
      valid_in        = valid_ff;
      rsp_tvalid_in   = rsp_tvalid_ff;
      rsp_tdata_in    = rsp_tdata_ff;
      ram_we          = 1'b0;
      ram_waddr       = clr_ff;
      ram_wdata       = 32'd0;
      ram_re          = 1'b0;
      ram_raddr       = '0;
      pl              = playing_ff;
      rh              = ~rfh_ff;
      pos             = '0;
      wh              = rfh_ff;
      wpos            = wp_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_SAMPLES: spsync_in    = csr_wdata[7:0];
            CSR_RESYNC:  resync_iv_in = csr_wdata;
            CSR_STEP:    step_in      = csr_wdata[23:0];
            CSR_BLINK:   blink_per_in = csr_wdata;
            default:     spsync_in    = spsync_ff;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               local_in = req_tdata[62:0];
               srt_in   = req_tdata[126:63];
               sst_in   = req_tdata[190:127];
               sw_in    = req_tdata[254:191];
               ew_in    = req_tdata[286:255];
               ef_in    = req_tdata[287];
               send_in  = 1'b0;
               valid_in = 1'b0;
               x0_in    = {1'b0, req_tdata[62:0]} - sync_time_ff;
               state_in = S_MPREP;
            end
         end
         S_MPREP: begin
            prod_in  = {64'd0, mag64(x0_ff)};
            md_in    = mag64(drift_ff);
            mneg_in  = x0_ff[63] ^ drift_ff[63];
            mcnt_in  = 6'd0;
            state_in = S_MUL;
         end
         S_MUL: begin
            // one multiplier bit per cycle, product shifts right
            prod_in = {msum, prod_ff[63:1]};
            mcnt_in = mcnt_ff + 6'd1;
            if (mcnt_ff == 6'd63) begin
               state_in = S_ADJ;
            end
         end
         S_ADJ: begin
            part_in  = {1'b0, local_ff} + base_ff;
            corr_in  = sat64(mval, mneg_ff);
            diff_in  = {1'b0, local_ff} - request_time_ff;
            state_in = S_ADJ2;
         end
         S_ADJ2: begin
            adj_in   = part_ff + corr_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            priority case (cmd_ff)
               CMD_TICK: begin
                  if ($signed({32'd0, resync_iv_ff}) < $signed(diff_ff)) begin
                     samples_in      = 8'd0;
                     best_rtt_in     = SMAX;
                     request_time_in = {1'b0, local_ff};
                     send_in         = 1'b1;
                  end
                  if (playing_ff != want_ff) begin
                     if (want_ff) begin
                        if (!($signed(adj_ff) < $signed(start_ff))) pl = 1'b1;
                     end else begin
                        if (!($signed(adj_ff) < $signed(stop_ff))) pl = 1'b0;
                     end
                  end
                  playing_in = pl;
                  if (pl) begin
                     if ($signed(due_ff) < $signed(adj_ff)) begin
                        state_in = S_RDADDR;
                     end
                  end else begin
                     dnd_in    = {mag64(adj_ff), 64'd0};
                     dsor_in   = {32'd0, per_v};
                     drem_in   = 64'd0;
                     quo_in    = 64'd0;
                     sticky_in = 1'b0;
                     dcnt_in   = 7'd63;
                     dblink_in = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               CMD_SYNC: begin
                  if (samples_ff < spsync_ff) begin
                     x0_in    = {1'b0, local_ff} - request_time_ff;
                     x1_in    = sst_ff - srt_ff;
                     x2_in    = srt_ff - request_time_ff;
                     x3_in    = sst_ff - {1'b0, local_ff};
                     state_in = S_SYNC2;
                  end
               end
               CMD_START: begin
                  start_in = sw_ff;
                  want_in  = 1'b1;
               end
               CMD_STOP: begin
                  stop_in = sw_ff;
                  want_in = 1'b0;
               end
               CMD_ENTRY: begin
                  // writes go to the half that is not being read
                  if (ef_ff) begin
                     wpos      = '0;
                     rp_in[wh] = '0;
                  end
                  ram_we    = 1'b1;
                  ram_waddr = AW'(wpos) + (wh ? HALF_A : AW'(0));
                  ram_wdata = ew_ff;
                  wp_in     = (wpos == WP_LAST) ? PW'(0) : wpos + PW'(1);
               end
               default: state_in = S_DONE;
            endcase
         end
         S_RDADDR: begin
            if (rp_ff[rh] >= HALF_R) begin
               rfh_in = ~rfh_ff;
               rh     = ~rh;
               pos    = (rp_ff[rh] >= HALF_R) ? RW'(0) : rp_ff[rh];
            end else begin
               pos = rp_ff[rh];
            end
            ram_re    = 1'b1;
            ram_raddr = AW'(pos) + (rh ? HALF_A : AW'(0));
            rp_in[rh] = pos + RW'(1);
            state_in  = S_ENTRY;
         end
         S_ENTRY: begin
            ent_in   = ram_rdata;
            sprod_in = 33'(hold_p1) * 33'(step_ff);
            valid_in = 1'b1;
            led_in   = ~led_ff;
            state_in = S_DUE;
         end
         S_DUE: begin
            due_in   = adj_ff + {31'd0, sprod_ff};
            state_in = S_DONE;
         end
         S_SYNC2: begin
            x0_in    = x0_ff - x1_ff;
            x1_in    = x2_ff + x3_ff;
            state_in = S_SYNC3;
         end
         S_SYNC3: begin
            // halving toward zero works on the magnitude
            x2_in    = {1'b0, d_v[63:1]};
            state_in = S_SYNC4;
         end
         S_SYNC4: begin
            if (samples_ff == 8'd0 || $signed(x0_ff) < $signed(best_rtt_ff)) begin
               best_rtt_in  = x0_ff;
               best_off_in  = off_v;
               best_time_in = {1'b0, local_ff};
            end
            samples_in = samples_nx[7:0];
            if (samples_nx < {1'b0, spsync_ff}) begin
               request_time_in = {1'b0, local_ff};
               send_in         = 1'b1;
               state_in        = S_DONE;
            end else begin
               state_in = S_DPREP;
            end
         end
         S_DPREP: begin
            x0_in        = best_off_ff - base_ff;
            x1_in        = best_time_ff - sync_time_ff;
            base_in      = best_off_ff;
            sync_time_in = best_time_ff;
            // first round sets the base only
            state_in     = (sync_time_ff == 64'd0) ? S_DONE : S_DPREP2;
         end
         S_DPREP2: begin
            if (d_v == 64'd0) begin
               drift_in = 64'd0;
               state_in = S_DONE;
            end else begin
               dnd_in    = {24'd0, m_v, 40'd0};
               dsor_in   = d_v;
               drem_in   = 64'd0;
               quo_in    = 64'd0;
               sticky_in = 1'b0;
               dcnt_in   = 7'd127;
               dneg_in   = x0_ff[63] ^ x1_ff[63];
               dblink_in = 1'b0;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            dnd_in    = {dnd_ff[126:0], 1'b0};
            drem_in   = dtake ? dsub[63:0] : drem2[63:0];
            quo_in    = {quo_ff[62:0], dtake};
            sticky_in = sticky_ff | quo_ff[63];
            dcnt_in   = dcnt_ff - 7'd1;
            if (dcnt_ff == 7'd0) begin
               if (dblink_ff) begin
                  led_in   = ~dtake;
                  state_in = S_DONE;
               end else begin
                  state_in = S_DSAT;
               end
            end
         end
         S_DSAT: begin
            drift_in = sat64(qv, dneg_ff);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {4'd0, adj_ff, playing_ff, led_ff, ent_m[7:0], ent_m[15:8],
                                ent_m[23:16], ent_m[31:24], valid_ff, send_ff};
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         spsync_ff       <= RST_SAMPLES;
         resync_iv_ff    <= RST_RESYNC;
         step_ff         <= RST_STEP;
         blink_per_ff    <= RST_BLINK;
         request_time_ff <= 64'd0;
         samples_ff      <= 8'd0;
         best_rtt_ff     <= SMAX;
         best_off_ff     <= 64'd0;
         best_time_ff    <= 64'd0;
         base_ff         <= 64'd0;
         drift_ff        <= 64'd0;
         sync_time_ff    <= 64'd0;
         start_ff        <= 64'd0;
         stop_ff         <= 64'd0;
         due_ff          <= 64'd0;
         want_ff         <= 1'b0;
         playing_ff      <= 1'b0;
         rfh_ff          <= 1'b1;
         led_ff          <= 1'b0;
         rp_ff[0]        <= '0;
         rp_ff[1]        <= '0;
         wp_ff           <= '0;
         clr_ff          <= '0;
         send_ff         <= 1'b0;
         valid_ff        <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         spsync_ff       <= spsync_in;
         resync_iv_ff    <= resync_iv_in;
         step_ff         <= step_in;
         blink_per_ff    <= blink_per_in;
         request_time_ff <= request_time_in;
         samples_ff      <= samples_in;
         best_rtt_ff     <= best_rtt_in;
         best_off_ff     <= best_off_in;
         best_time_ff    <= best_time_in;
         base_ff         <= base_in;
         drift_ff        <= drift_in;
         sync_time_ff    <= sync_time_in;
         start_ff        <= start_in;
         stop_ff         <= stop_in;
         due_ff          <= due_in;
         want_ff         <= want_in;
         playing_ff      <= playing_in;
         rfh_ff          <= rfh_in;
         led_ff          <= led_in;
         rp_ff[0]        <= rp_in[0];
         rp_ff[1]        <= rp_in[1];
         wp_ff           <= wp_in;
         clr_ff          <= clr_in;
         send_ff         <= send_in;
         valid_ff        <= valid_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      local_ff     <= local_in;
      srt_ff       <= srt_in;
      sst_ff       <= sst_in;
      sw_ff        <= sw_in;
      ew_ff        <= ew_in;
      ef_ff        <= ef_in;
      prod_ff      <= prod_in;
      md_ff        <= md_in;
      mcnt_ff      <= mcnt_in;
      mneg_ff      <= mneg_in;
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      x2_ff        <= x2_in;
      x3_ff        <= x3_in;
      part_ff      <= part_in;
      corr_ff      <= corr_in;
      adj_ff       <= adj_in;
      diff_ff      <= diff_in;
      drem_ff      <= drem_in;
      dsor_ff      <= dsor_in;
      quo_ff       <= quo_in;
      dnd_ff       <= dnd_in;
      dcnt_ff      <= dcnt_in;
      sticky_ff    <= sticky_in;
      dneg_ff      <= dneg_in;
      dblink_ff    <= dblink_in;
      ent_ff       <= ent_in;
      sprod_ff     <= sprod_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   `SCTP_ASSERT_NXT(a_accept_starts_mul, req_tvalid && req_tready, state_ff == S_MPREP, "accepted transaction did not start the multiply")
   `SCTP_ASSERT_IMP(a_entry_needs_play, rsp_tvalid && rsp_tdata[1], rsp_tdata[35], "entry emitted while not playing")
   `SCTP_ASSERT_IMP(a_no_entry_zero, rsp_tvalid && !rsp_tdata[1], rsp_tdata[33:2] == 32'd0, "colour fields not zero without an entry")
   `SCTP_ASSERT_IMP(a_ram_single_use, ram_we, !ram_re, "entry buffer written and read in one cycle")

endmodule

[tb/playback_checker.sv]
module playback_checker
   import sctp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [2:0]             req_tuser,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     errors,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        send_req;
      logic        ent_valid;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  hold;
      logic        led;
      logic        play;
      logic [63:0] adj;
   } playback_out_t;

   playback_out_t expected_q[$];

   logic [7:0]  cfg_samples;
   logic [31:0] cfg_resync;
   logic [23:0] cfg_step;
   logic [31:0] cfg_blink;

   logic [63:0] req_at, low_rtt, low_off, low_at, offs_base, drift, synced_at;
   logic [63:0] play_from, play_until, due_at;
   logic [7:0]  n_taken;
   logic        go_play, in_play, first_half, led;
   logic [31:0] store [0:511];
   logic [8:0]  rd_pos [0:1];
   logic [8:0]  wr_pos;

   initial begin
      errors  = 0;
      pending = 0;
   end

   function automatic logic [63:0] magnitude(input logic [63:0] v);
      return v[63] ? (~v + 64'd1) : v;
   endfunction

   function automatic logic [63:0] clamp_signed(input logic [63:0] m, input logic neg);
      if (!neg) return (m > SMAX) ? SMAX : m;
      if (m > MSB) m = MSB;
      return ~m + 64'd1;
   endfunction

   function automatic logic [63:0] drift_ratio(input logic [63:0] doff, input logic [63:0] dt);
      logic [127:0] num, quo;
      logic [63:0]  lo;
      if (dt == 64'd0) return 64'd0;
      num = {64'd0, magnitude(doff)} << 40;
      quo = num / {64'd0, magnitude(dt)};
      lo  = (quo[127:64] != 64'd0) ? {64{1'b1}} : quo[63:0];
      return clamp_signed(lo, doff[63] ^ dt[63]);
   endfunction

   function automatic logic [63:0] corrected_time(input logic [63:0] lt);
      logic [63:0]  dt, m;
      logic [127:0] p;
      dt = lt - synced_at;
      p  = {64'd0, magnitude(drift)} * {64'd0, magnitude(dt)};
      m  = (p[127:104] != 24'd0) ? {64{1'b1}} : p[103:40];
      return lt + offs_base + clamp_signed(m, dt[63] ^ drift[63]);
   endfunction

   task automatic clear_state();
      cfg_samples = RST_SAMPLES;
      cfg_resync  = RST_RESYNC;
      cfg_step    = RST_STEP;
      cfg_blink   = RST_BLINK;
      req_at = 0; low_rtt = SMAX; low_off = 0; low_at = 0; offs_base = 0;
      drift = 0; synced_at = 0; play_from = 0; play_until = 0; due_at = 0;
      n_taken = 0; go_play = 0; in_play = 0; first_half = 1; led = 0;
      for (int i = 0; i < 512; i++) store[i] = 0;
      rd_pos[0] = 0; rd_pos[1] = 0; wr_pos = 0;
   endtask

   task automatic predict_playback(input logic [2:0] cmd, input logic [REQ_DATA_W-1:0] d);
      playback_out_t o;
      logic [63:0] lt, t2, t3, sw, rtt, sum, off, per, q;
      logic [31:0] word, e;
      int          rh, wh;
      lt   = {1'b0, d[62:0]};
      t2   = d[126:63];
      t3   = d[190:127];
      sw   = d[254:191];
      word = d[286:255];
      o    = '0;
      o.adj = corrected_time(lt);
      case (cmd)
         CMD_TICK: begin
            if ($signed({32'd0, cfg_resync}) < $signed(lt - req_at)) begin
               n_taken = 0; low_rtt = SMAX; req_at = lt; o.send_req = 1;
            end
            if (in_play != go_play) begin
               if (go_play) begin
                  if (!($signed(o.adj) < $signed(play_from))) in_play = 1;
               end else begin
                  if (!($signed(o.adj) < $signed(play_until))) in_play = 0;
               end
            end
            if (in_play) begin
               if ($signed(due_at) < $signed(o.adj)) begin
                  rh = first_half ? 0 : 1;
                  if (rd_pos[rh] >= 9'd256) begin
                     first_half = !first_half;
                     rh = 1 - rh;
                     if (rd_pos[rh] >= 9'd256) rd_pos[rh] = 0;
                  end
                  e = store[rh * 256 + rd_pos[rh]];
                  rd_pos[rh] = rd_pos[rh] + 9'd1;
                  o.red = e[31:24]; o.green = e[23:16]; o.blue = e[15:8]; o.hold = e[7:0];
                  o.ent_valid = 1;
                  due_at = o.adj + ({56'd0, e[7:0]} + 64'd1) * {40'd0, cfg_step};
                  led = !led;
               end
            end else begin
               per = (cfg_blink != 0) ? {32'd0, cfg_blink} : 64'd1;
               q   = magnitude(o.adj) / per;
               led = !q[0];
            end
         end
         CMD_SYNC: begin
            if (n_taken < cfg_samples) begin
               rtt = (lt - req_at) - (t3 - t2);
               sum = (t2 - req_at) + (t3 - lt);
               off = clamp_signed(magnitude(sum) >> 1, sum[63]);
               if (n_taken == 0 || $signed(rtt) < $signed(low_rtt)) begin
                  low_rtt = rtt; low_off = off; low_at = lt;
               end
               n_taken = n_taken + 8'd1;
               if (n_taken < cfg_samples) begin
                  req_at = lt; o.send_req = 1;
               end else begin
                  if (synced_at != 0) drift = drift_ratio(low_off - offs_base, low_at - synced_at);
                  offs_base = low_off;
                  synced_at = low_at;
               end
            end
         end
         CMD_START: begin
            play_from = sw; go_play = 1;
         end
         CMD_STOP: begin
            play_until = sw; go_play = 0;
         end
         CMD_ENTRY: begin
            wh = first_half ? 1 : 0;
            if (d[287]) begin
               wr_pos = 0; rd_pos[wh] = 0;
            end
            if (wr_pos >= 9'd256) wr_pos = 0;
            store[wh * 256 + wr_pos] = word;
            wr_pos = wr_pos + 9'd1;
            if (wr_pos >= 9'd256) wr_pos = 0;
         end
         default: ;
      endcase
      o.led  = led;
      o.play = in_play;
      expected_q.push_back(o);
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 10)
            $display("mismatch %s: expected %h, got %h", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      playback_out_t w;
      if (reset) begin
         clear_state();
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SAMPLES: cfg_samples = csr_wdata[7:0];
               CSR_RESYNC:  cfg_resync  = csr_wdata;
               CSR_STEP:    cfg_step    = csr_wdata[23:0];
               CSR_BLINK:   cfg_blink   = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result transaction %h", rsp_tdata);
            end else begin
               w = expected_q.pop_front();
               check_field("send_sync_request", w.send_req, rsp_tdata[0]);
               check_field("entry_valid", w.ent_valid, rsp_tdata[1]);
               check_field("red", w.red, rsp_tdata[9:2]);
               check_field("green", w.green, rsp_tdata[17:10]);
               check_field("blue", w.blue, rsp_tdata[25:18]);
               check_field("hold_steps", w.hold, rsp_tdata[33:26]);
               check_field("led_on", w.led, rsp_tdata[34]);
               check_field("playing", w.play, rsp_tdata[35]);
               check_field("adjusted_time", w.adj, rsp_tdata[99:36]);
            end
         end
         if (req_tvalid && req_tready) predict_playback(req_tuser, req_tdata);
      end
      pending = expected_q.size();
   end

endmodule

[tb/tb.sv]
module tb
   import sctp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_tvalid = 0;
   logic                   req_tready;
   logic [2:0]             req_tuser = CMD_TICK;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SAMPLES;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int          errors, pending;
   bit          stall_req = 0;
   bit          no_gaps = 0;
   logic [62:0] now_us = 0;
   logic [63:0] skew = 0;

   always #1 clock = ~clock;

   synced_clock_timed_playback_unit dut (.*);

   playback_checker chk (.*);

   initial begin
      #20_000_000;
      $display("tb: errors");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      if (r < 99) return $urandom_range(5, 40);
      return $urandom_range(100, 400);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // result side: random gaps, plus one long hold-off on request
   initial begin
      int g;
      forever begin
         @(posedge clock);
         if (stall_req) begin
            rsp_tready <= 0;
            repeat (3000) @(posedge clock);
            stall_req = 0;
         end else begin
            g = pick_gap();
            if (g > 0) begin
               rsp_tready <= 0;
               repeat (g) @(posedge clock);
            end
            rsp_tready <= 1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   task automatic put(input logic [2:0] c, input logic [62:0] lt, input logic [63:0] srt,
                      input logic [63:0] sst, input logic [63:0] sw, input logic [31:0] word,
                      input logic first);
      bit ok;
      int g;
      req_tuser  <= c;
      req_tdata  <= {first, word, sw, sst, srt, lt};
      req_tvalid <= 1;
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
      g = pick_gap();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_tvalid <= 0;
      @(posedge clock);
      wait (pending == 0);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_regs(input logic [7:0] spp, input logic [31:0] rs,
                             input logic [23:0] st, input logic [31:0] bl);
      csr_we <= 1; csr_index <= CSR_SAMPLES; csr_wdata <= {24'd0, spp};
      @(posedge clock);
      csr_index <= CSR_RESYNC; csr_wdata <= rs;
      @(posedge clock);
      csr_index <= CSR_STEP; csr_wdata <= {8'd0, st};
      @(posedge clock);
      csr_index <= CSR_BLINK; csr_wdata <= bl;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic random_item();
      int r;
      logic [63:0] a;
      now_us = now_us + $urandom_range(0, 3000);
      r = $urandom_range(0, 99);
      a = {1'b0, now_us} + skew;
      if (r < 45) begin
         put(CMD_TICK, now_us, rand64(), rand64(), rand64(), $urandom,
             1'($urandom_range(0, 1)));
      end else if (r < 65) begin
         if ($urandom_range(0, 9) == 0) begin
            put(CMD_SYNC, now_us, rand64(), rand64(), rand64(), $urandom, 0);
         end else begin
            a = a - 64'($urandom_range(0, 400));
            put(CMD_SYNC, now_us, a, a + 64'($urandom_range(0, 200)), rand64(), $urandom, 0);
         end
      end else if (r < 75) begin
         a = ($urandom_range(0, 9) == 0) ? rand64() : a + 64'($urandom_range(0, 20000));
         put((r < 70) ? CMD_START : CMD_STOP, now_us, rand64(), rand64(), a, $urandom, 0);
      end else if (r < 95) begin
         put(CMD_ENTRY, now_us, rand64(), rand64(), rand64(), $urandom,
             $urandom_range(0, 15) == 0);
      end else if (r < 97) begin
         put(3'($urandom_range(5, 7)), now_us, rand64(), rand64(), rand64(), $urandom, 1);
      end else begin
         a = rand64();
         put(CMD_TICK, a[62:0], rand64(), rand64(), rand64(), $urandom, 0);
      end
   endtask

   initial begin
      logic [7:0]  c_spp [5] = '{8'd2, 8'd1, 8'd255, 8'd0, 8'd4};
      logic [31:0] c_rs  [5] = '{32'd3000, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd20000};
      logic [23:0] c_st  [5] = '{24'd100, 24'hFF_FFFF, 24'd1, 24'd7, 24'd50};
      logic [31:0] c_bl  [5] = '{32'd500, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd3000};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every command, round close
      put(CMD_TICK, 63'd0, 0, 0, 0, 0, 0);
      put(CMD_TICK, {63{1'b1}}, 0, 0, 0, 0, 0);
      put(CMD_TICK, 63'd1000, 0, 0, 0, 0, 0);
      put(CMD_SYNC, 63'd2000, SMAX, MSB, 0, 0, 0);
      put(CMD_SYNC, 63'd2500, MSB, SMAX, 0, 0, 0);
      put(CMD_SYNC, 63'd3000, 64'd1500, 64'd1600, 0, 0, 0);
      for (int i = 0; i < 6; i++)
         put(CMD_SYNC, 63'(4000 + i * 100), 64'(9000 + i * 100), 64'(9010 + i * 100), 0, 0, 0);
      put(CMD_SYNC, 63'd9000, 64'd1, 64'd2, 0, 0, 0);
      put(CMD_ENTRY, 63'd9100, 0, 0, 0, 32'hFFFF_FFFF, 1);
      put(CMD_ENTRY, 63'd9200, 0, 0, 0, 32'h0000_0000, 0);
      put(CMD_ENTRY, 63'd9300, 0, 0, 0, 32'h1234_5601, 0);
      put(CMD_START, 63'd9400, 0, 0, MSB, 0, 0);
      put(CMD_TICK, 63'd9500, 0, 0, 0, 0, 0);
      put(CMD_TICK, 63'd90000, 0, 0, 0, 0, 0);
      put(CMD_TICK, 63'd200000, 0, 0, 0, 0, 0);
      put(CMD_STOP, 63'd200100, 0, 0, SMAX, 0, 0);
      put(CMD_TICK, 63'd300000, 0, 0, 0, 0, 0);
      put(3'd5, 63'd300100, rand64(), rand64(), rand64(), $urandom, 1);
      put(3'd7, 63'd300200, rand64(), rand64(), rand64(), $urandom, 1);
      put(CMD_STOP, 63'd300300, 0, 0, MSB, 0, 0);
      put(CMD_TICK, 63'd300400, 0, 0, 0, 0, 0);
      settle();

      for (int p = 0; p < 5; p++) begin
         write_regs(c_spp[p], c_rs[p], c_st[p], c_bl[p]);
         skew = 64'($signed($urandom_range(0, 2000000)) - 1000000);
         now_us = {23'd0, $urandom, 8'd0};
         no_gaps = (p == 2);
         for (int i = 0; i < 306; i++) begin
            if (p == 0 && i == 100) begin
               req_tvalid <= 0;
               @(posedge clock);
               wait (pending == 0);
            end
            if (p == 0 && i == 150) stall_req = 1;
            random_item();
         end
         settle();
      end

      if (errors == 0 && pending == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
